/* rtl/tkm_pkg.sv */
`default_nettype none
package tkm_pkg;

  // Sizes of the stores and fields
  localparam int NUM_HAPS  = 1024;
  localparam int NUM_SITES = 256;
  localparam int MAX_SLOTS = 64;

  localparam int HAP_W   = 10;
  localparam int LEN_W   = 16;
  localparam int SITE_W  = 8;
  localparam int SLOT_W  = 6;
  localparam int CNT_W   = 7;
  localparam int CAP_W   = 7;
  localparam int TOT_W   = 32;
  localparam int LIST_AW = SITE_W + SLOT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(60);

  // Item kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // One stored list entry
  typedef struct packed {
    logic [HAP_W-1:0] hap;
    logic [LEN_W-1:0] len;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic latch_in;
    logic fetch;
    logic load;
    logic scan_rd;
    logic shift;
    logic tot_rd;
    logic step;
    logic place;
    logic read_res;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic kind;
    logic scan_end;
    logic entry_lt;
    logic entry_eq;
    logic tot_gt;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/tkm_if.sv */
`default_nettype none
interface tkm_req_if;
  import tkm_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [HAP_W-1:0]    haplotype;
  logic [LEN_W-1:0]    match_length;
  logic [SITE_W-1:0]   site;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, kind, haplotype, match_length, site, slot, input ready);
  modport sink (input valid, kind, haplotype, match_length, site, slot, output ready);
endinterface

interface tkm_rsp_if;
  import tkm_pkg::*;

  logic                valid;
  logic                ready;
  logic                inserted;
  logic [SLOT_W-1:0]   insert_position;
  logic [CNT_W-1:0]    entry_count;
  logic [TOT_W-1:0]    haplotype_total;
  logic [HAP_W-1:0]    read_haplotype;
  logic [LEN_W-1:0]    read_length;
  logic                read_valid;

  modport source (output valid, inserted, insert_position, entry_count, haplotype_total,
                  read_haplotype, read_length, read_valid, input ready);
  modport sink (input valid, inserted, insert_position, entry_count, haplotype_total,
                read_haplotype, read_length, read_valid, output ready);
endinterface
`default_nettype wire

/* rtl/tkm_ctrl.sv */
`default_nettype none
module tkm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  tkm_req_if.sink            req,
  input  wire tkm_pkg::sts_t sts,
  output tkm_pkg::cmd_t      cmd
);
  import tkm_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_FETCH    = 4'd2;
  localparam logic [3:0] S_LOAD     = 4'd3;
  localparam logic [3:0] S_SCAN_RD  = 4'd4;
  localparam logic [3:0] S_SCAN_CHK = 4'd5;
  localparam logic [3:0] S_TOT_CHK  = 4'd6;
  localparam logic [3:0] S_PLACE    = 4'd7;
  localparam logic [3:0] S_RD_DONE  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sequence one transaction at a time
  always_comb begin
    state_next = state;
    cmd        = '0;
    req.ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = (sts.kind == KIND_READ) ? S_RD_DONE : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (sts.scan_end) begin
          state_next = S_PLACE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next  = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts.entry_lt) begin
          cmd.shift  = 1'b1;
          cmd.step   = 1'b1;
          state_next = S_SCAN_RD;
        end else if (sts.entry_eq) begin
          cmd.tot_rd = 1'b1;
          state_next = S_TOT_CHK;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_TOT_CHK: begin
        if (sts.tot_gt) begin
          state_next = S_PLACE;
        end else begin
          cmd.shift  = 1'b1;
          cmd.step   = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_PLACE: begin
        if (sts.out_free) begin
          cmd.place  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD_DONE: begin
        if (sts.out_free) begin
          cmd.read_res = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/tkm_dp.sv */
`default_nettype none
module tkm_dp (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [tkm_pkg::CAP_W-1:0] cfg_data,
  tkm_req_if.sink                       req,
  tkm_rsp_if.source                     rsp,
  input  wire tkm_pkg::cmd_t            cmd,
  output tkm_pkg::sts_t                 sts
);
  import tkm_pkg::*;

  // Stores
  logic [TOT_W-1:0] totals [NUM_HAPS];
  logic [CNT_W-1:0] counts [NUM_SITES];
  entry_t           lists  [NUM_SITES * MAX_SLOTS];

  logic [CAP_W-1:0]  capacity;
  logic [HAP_W-1:0]  clr_addr;

  logic              kind_r;
  logic [HAP_W-1:0]  hap_r;
  logic [LEN_W-1:0]  len_r;
  logic [SITE_W-1:0] site_r;
  logic [SLOT_W-1:0] slot_r;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  newn_r;
  logic [CNT_W-1:0]  pos_r;
  logic [TOT_W-1:0]  total_r;

  logic [TOT_W-1:0]  tot_rdata;
  logic [CNT_W-1:0]  cnt_rdata;
  entry_t            lst_rdata;

  logic [CNT_W-1:0]  eff_cap;
  logic [TOT_W:0]    sum;
  logic [TOT_W-1:0]  sat_total;
  logic [CNT_W-1:0]  pos_m1;
  logic              fits;

  logic              tot_we;
  logic [HAP_W-1:0]  tot_waddr;
  logic [TOT_W-1:0]  tot_wdata;
  logic [HAP_W-1:0]  tot_raddr;
  logic              cnt_we;
  logic [SITE_W-1:0] cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic              lst_we;
  logic [LIST_AW-1:0] lst_waddr;
  entry_t            lst_wdata;
  logic              lst_re;
  logic [LIST_AW-1:0] lst_raddr;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + HAP_W'(1);
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r <= req.kind;
      hap_r  <= req.haplotype;
      len_r  <= req.match_length;
      site_r <= req.site;
      slot_r <= req.slot;
    end
  end

  // Saturating total and list growth
  always_comb begin
    eff_cap   = (capacity > CAP_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : capacity;
    sum       = {1'b0, tot_rdata} + {{(TOT_W + 1 - LEN_W){1'b0}}, len_r};
    sat_total = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
    pos_m1    = pos_r - CNT_W'(1);
    fits      = pos_r < newn_r;
  end

  // Scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count_r <= cnt_rdata;
      newn_r  <= (cnt_rdata < eff_cap) ? cnt_rdata + CNT_W'(1) : cnt_rdata;
      pos_r   <= cnt_rdata;
      total_r <= sat_total;
    end else if (cmd.step) begin
      pos_r <= pos_m1;
    end
  end

  // Totals port selection
  always_comb begin
    tot_we    = cmd.clear | (cmd.load & (kind_r == KIND_ADD));
    tot_waddr = cmd.clear ? clr_addr : hap_r;
    tot_wdata = cmd.clear ? '0 : sat_total;
    tot_raddr = cmd.tot_rd ? lst_rdata.hap : hap_r;
  end

  always_ff @(posedge clk) begin
    if (tot_we) totals[tot_waddr] <= tot_wdata;
    if (cmd.fetch | cmd.tot_rd) tot_rdata <= totals[tot_raddr];
  end

  // Counts port selection
  always_comb begin
    cnt_we    = (cmd.clear & (clr_addr < HAP_W'(NUM_SITES))) | cmd.place;
    cnt_waddr = cmd.clear ? clr_addr[SITE_W-1:0] : site_r;
    cnt_wdata = cmd.clear ? '0 : newn_r;
  end

  always_ff @(posedge clk) begin
    if (cnt_we) counts[cnt_waddr] <= cnt_wdata;
    if (cmd.fetch) cnt_rdata <= counts[site_r];
  end

  // List port selection: shift an entry down or drop in the new match
  always_comb begin
    lst_we    = (cmd.shift | cmd.place) & fits;
    lst_waddr = {site_r, pos_r[SLOT_W-1:0]};
    lst_wdata = cmd.place ? entry_t'{hap: hap_r, len: len_r} : lst_rdata;
    lst_re    = cmd.fetch | cmd.scan_rd;
    lst_raddr = cmd.scan_rd ? {site_r, pos_m1[SLOT_W-1:0]} : {site_r, slot_r};
  end

  always_ff @(posedge clk) begin
    if (lst_we) lists[lst_waddr] <= lst_wdata;
    if (lst_re) lst_rdata <= lists[lst_raddr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.place | cmd.read_res) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.place) begin
      rsp.inserted        <= fits;
      rsp.insert_position <= fits ? pos_r[SLOT_W-1:0] : '0;
      rsp.entry_count     <= newn_r;
      rsp.haplotype_total <= total_r;
      rsp.read_haplotype  <= '0;
      rsp.read_length     <= '0;
      rsp.read_valid      <= 1'b0;
    end else if (cmd.read_res) begin
      rsp.inserted        <= 1'b0;
      rsp.insert_position <= '0;
      rsp.entry_count     <= count_r;
      rsp.haplotype_total <= '0;
      if ({1'b0, slot_r} < count_r) begin
        rsp.read_haplotype <= lst_rdata.hap;
        rsp.read_length    <= lst_rdata.len;
        rsp.read_valid     <= 1'b1;
      end else begin
        rsp.read_haplotype <= '0;
        rsp.read_length    <= '0;
        rsp.read_valid     <= 1'b0;
      end
    end
  end

  // Status back to the controller
  always_comb begin
    sts.clear_done = clr_addr == HAP_W'(NUM_HAPS - 1);
    sts.kind       = kind_r;
    sts.scan_end   = pos_r == '0;
    sts.entry_lt   = lst_rdata.len < len_r;
    sts.entry_eq   = lst_rdata.len == len_r;
    sts.tot_gt     = tot_rdata > total_r;
    sts.out_free   = ~rsp.valid | rsp.ready;
  end

endmodule
`default_nettype wire

/* rtl/top_k_match_list_per_site.sv */
`default_nettype none
// Per-site top-k match lists with per-haplotype running length totals.
//
// Channels: req carries one transaction (kind, haplotype, match_length, site,
// slot); rsp returns exactly one result per request. Both use valid/ready and
// move a transaction on a clock edge where both are high. cfg_we/cfg_data
// write the list capacity (effective limit is min(capacity, 64)); write it
// only while no transaction is in flight.
//
// One request is processed at a time; the next can be taken in the cycle
// after the result registers. Steps from accept to result valid:
//   read: fetch the count and the entry, load, then register the result.
//   add:  fetch and load, then per list entry passed a read and a compare
//         (and a total read if of equal length); the walk stops on an entry
//         kept ahead and then places the new match. The walk visits one entry
//         per step through the list memory's read port.
// Reset: after rst drops, a sweep over all totals addresses zeroes all
// totals and list counts; req.ready stays low during it. Capacity returns to 60.
// Stall: the result sits in an output register; a new request is accepted
// while it waits, but the next result is held until rsp.ready takes the old one.
module top_k_match_list_per_site (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [tkm_pkg::CAP_W-1:0] cfg_data,
  tkm_req_if.sink                        req,
  tkm_rsp_if.source                      rsp
);
  import tkm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tkm_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .req (req),
    .sts (sts),
    .cmd (cmd)
  );

  tkm_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .rsp      (rsp),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Only one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while another is in flight");

  // List counts never exceed the slot count
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.entry_count <= CNT_W'(MAX_SLOTS))
    else $error("entry count above slot limit");

  // A kept match lands inside the list
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.inserted |-> {1'b0, rsp.insert_position} < rsp.entry_count)
    else $error("insert position beyond entry count");

  // Add and read results never mix
  a_kind_excl: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.read_valid |-> !rsp.inserted && rsp.haplotype_total == '0)
    else $error("read result carries add fields");

endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import tkm_pkg::*;

  localparam int PHASE_ITEMS = 135;
  localparam int HOLD_PHASE = 3;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 250;
  localparam int DIR_ROWS = 19;

  localparam logic [SITE_W-1:0] HOT_SITES [4] = '{8'd3, 8'd77, 8'd128, 8'd255};
  localparam logic [HAP_W-1:0] HAP_POOL [6] = '{10'd0, 10'd1, 10'd2, 10'd777, 10'd1022, 10'd1023};
  localparam logic [LEN_W-1:0] LEN_POOL [5] = '{16'd0, 16'd1, 16'd100, 16'h8000, 16'hFFFF};

  typedef struct packed {
    logic              kind;
    logic [HAP_W-1:0]  haplotype;
    logic [LEN_W-1:0]  match_length;
    logic [SITE_W-1:0] site;
    logic [SLOT_W-1:0] slot;
  } request_t;

  typedef struct packed {
    logic              inserted;
    logic [SLOT_W-1:0] insert_position;
    logic [CNT_W-1:0]  entry_count;
    logic [TOT_W-1:0]  haplotype_total;
    logic [HAP_W-1:0]  read_haplotype;
    logic [LEN_W-1:0]  read_length;
    logic              read_valid;
  } result_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    result_t  res;
  } row_t;

  // Directed rows: typed results only where obvious, the rest go to the predictor
  localparam row_t PLAN [DIR_ROWS] = '{
    '{'{KIND_READ, 10'd0, 16'd0, 8'd0, 6'd0}, 1'b1,
      '{1'b0, 6'd0, 7'd0, 32'd0, 10'd0, 16'd0, 1'b0}},
    '{'{KIND_ADD, 10'd0, 16'd0, 8'd0, 6'd0}, 1'b1,
      '{1'b1, 6'd0, 7'd1, 32'd0, 10'd0, 16'd0, 1'b0}},
    '{'{KIND_ADD, 10'd1023, 16'hFFFF, 8'd255, 6'd0}, 1'b1,
      '{1'b1, 6'd0, 7'd1, 32'd65535, 10'd0, 16'd0, 1'b0}},
    '{'{KIND_READ, 10'd0, 16'd0, 8'd255, 6'd0}, 1'b1,
      '{1'b0, 6'd0, 7'd1, 32'd0, 10'd1023, 16'hFFFF, 1'b1}},
    '{'{KIND_READ, 10'd0, 16'd0, 8'd255, 6'd63}, 1'b1,
      '{1'b0, 6'd0, 7'd1, 32'd0, 10'd0, 16'd0, 1'b0}},
    '{'{KIND_READ, 10'd0, 16'd0, 8'd0, 6'd1}, 1'b1,
      '{1'b0, 6'd0, 7'd1, 32'd0, 10'd0, 16'd0, 1'b0}},
    '{'{KIND_READ, 10'd0, 16'd0, 8'd0, 6'd0}, 1'b1,
      '{1'b0, 6'd0, 7'd1, 32'd0, 10'd0, 16'd0, 1'b1}},
    '{'{KIND_ADD, 10'd1023, 16'hFFFF, 8'd255, 6'd0}, 1'b0, '0},
    '{'{KIND_ADD, 10'd5, 16'hFFFF, 8'd255, 6'd0}, 1'b0, '0},
    '{'{KIND_ADD, 10'd5, 16'hFFFF, 8'd255, 6'd0}, 1'b0, '0},
    '{'{KIND_ADD, 10'd6, 16'd1, 8'd255, 6'd0}, 1'b0, '0},
    '{'{KIND_ADD, 10'd7, 16'h8000, 8'd255, 6'd0}, 1'b0, '0},
    '{'{KIND_ADD, 10'h2AA, 16'h5555, 8'h55, 6'h2A}, 1'b0, '0},
    '{'{KIND_ADD, 10'h155, 16'hAAAA, 8'hAA, 6'h15}, 1'b0, '0},
    '{'{KIND_READ, 10'd0, 16'd0, 8'd255, 6'd0}, 1'b0, '0},
    '{'{KIND_READ, 10'd0, 16'd0, 8'd255, 6'd5}, 1'b0, '0},
    '{'{KIND_READ, 10'd0, 16'd0, 8'd255, 6'd6}, 1'b0, '0},
    '{'{KIND_READ, 10'h3FF, 16'hFFFF, 8'hAA, 6'h3F}, 1'b0, '0},
    '{'{KIND_READ, 10'd0, 16'd0, 8'h55, 6'd0}, 1'b0, '0}
  };

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CAP_W-1:0] cfg_data;

  tkm_req_if req_ch ();
  tkm_rsp_if rsp_ch ();

  top_k_match_list_per_site i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  // Predictor state: totals, list fill levels, list contents, capacity
  bit [TOT_W-1:0] run_totals [NUM_HAPS];
  bit [CNT_W-1:0] list_fill [NUM_SITES];
  bit [HAP_W-1:0] list_hap [NUM_SITES][MAX_SLOTS];
  bit [LEN_W-1:0] list_len [NUM_SITES][MAX_SLOTS];
  bit [CAP_W-1:0] cap_reg = CAP_RESET;

  result_t due_results [$];
  int errors = 0;
  int phase_no = 0;
  bit calm = 1'b0;

  int adds_seen = 0;
  int adds_kept = 0;
  int reads_seen = 0;
  int reads_hit = 0;
  int longest_list = 0;
  int cap_settings = 0;
  bit saturated = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one transaction to the predictor state and return its result
  function automatic result_t list_step(input request_t r);
    result_t res;
    logic [TOT_W:0] sum;
    logic [TOT_W-1:0] total;
    int limit;
    int count;
    int fill;
    int j;
    bit stop;
    res = '0;
    if (r.kind == KIND_READ) begin
      reads_seen++;
      count = list_fill[r.site];
      res.entry_count = CNT_W'(count);
      if (r.slot < count) begin
        res.read_haplotype = list_hap[r.site][r.slot];
        res.read_length = list_len[r.site][r.slot];
        res.read_valid = 1'b1;
        reads_hit++;
      end
      return res;
    end
    adds_seen++;
    sum = {1'b0, run_totals[r.haplotype]} + {17'd0, r.match_length};
    total = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
    run_totals[r.haplotype] = total;
    res.haplotype_total = total;
    if (total == '1) saturated = 1'b1;
    limit = (cap_reg < MAX_SLOTS) ? int'(cap_reg) : MAX_SLOTS;
    count = list_fill[r.site];
    fill = (count < limit) ? count + 1 : count;
    j = count - 1;
    // Walk from the tail past shorter entries, shifting them down
    while (j >= 0 && list_len[r.site][j] < r.match_length) begin
      if (j + 1 < fill) begin
        list_len[r.site][j+1] = list_len[r.site][j];
        list_hap[r.site][j+1] = list_hap[r.site][j];
      end
      j--;
    end
    // Then past equal lengths whose total is not larger
    stop = 1'b0;
    while (j >= 0 && !stop && list_len[r.site][j] == r.match_length) begin
      if (run_totals[list_hap[r.site][j]] > total) begin
        stop = 1'b1;
      end else begin
        if (j + 1 < fill) begin
          list_len[r.site][j+1] = list_len[r.site][j];
          list_hap[r.site][j+1] = list_hap[r.site][j];
        end
        j--;
      end
    end
    if (j + 1 < fill) begin
      list_len[r.site][j+1] = r.match_length;
      list_hap[r.site][j+1] = r.haplotype;
      res.inserted = 1'b1;
      res.insert_position = SLOT_W'(j + 1);
      adds_kept++;
    end
    list_fill[r.site] = CNT_W'(fill);
    res.entry_count = CNT_W'(fill);
    if (fill > longest_list) longest_list = fill;
    return res;
  endfunction

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    errors++;
  endtask

  task automatic check_result(input result_t want, input result_t got);
    if (got.inserted !== want.inserted)
      report("inserted", want.inserted, got.inserted);
    if (got.insert_position !== want.insert_position)
      report("insert_position", want.insert_position, got.insert_position);
    if (got.entry_count !== want.entry_count)
      report("entry_count", want.entry_count, got.entry_count);
    if (got.haplotype_total !== want.haplotype_total)
      report("haplotype_total", want.haplotype_total, got.haplotype_total);
    if (got.read_haplotype !== want.read_haplotype)
      report("read_haplotype", want.read_haplotype, got.read_haplotype);
    if (got.read_length !== want.read_length)
      report("read_length", want.read_length, got.read_length);
    if (got.read_valid !== want.read_valid)
      report("read_valid", want.read_valid, got.read_valid);
  endtask

  // Offer one transaction, hold it until accepted, then queue its result
  task automatic send_request(input request_t r, input bit typed, input result_t typed_res);
    result_t predicted;
    req_ch.valid <= 1'b1;
    req_ch.kind <= r.kind;
    req_ch.haplotype <= r.haplotype;
    req_ch.match_length <= r.match_length;
    req_ch.site <= r.site;
    req_ch.slot <= r.slot;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    predicted = list_step(r);
    due_results.push_back(typed ? typed_res : predicted);
  endtask

  // Drop valid for a random burst now and then
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every queued result has come back
  task automatic drain_phase();
    req_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_reg = value;
    cap_settings++;
  endtask

  // Mostly hot sites, pooled haplotypes and lengths so lists fill and ties occur
  task automatic random_request(output request_t r);
    int pick;
    int fill;
    r.kind = ($urandom_range(0, 9) < 7) ? KIND_ADD : KIND_READ;
    pick = $urandom_range(0, 7);
    if (pick < 4) r.site = HOT_SITES[0];
    else if (pick < 6) r.site = HOT_SITES[$urandom_range(1, 3)];
    else r.site = SITE_W'($urandom_range(0, NUM_SITES - 1));
    if ($urandom_range(0, 9) < 4) r.haplotype = HAP_POOL[$urandom_range(0, 5)];
    else r.haplotype = HAP_W'($urandom_range(0, NUM_HAPS - 1));
    pick = $urandom_range(0, 9);
    if (pick < 3) r.match_length = LEN_POOL[$urandom_range(0, 4)];
    else if (pick < 5) r.match_length = LEN_W'($urandom_range(0, 3));
    else r.match_length = LEN_W'($urandom_range(0, 65535));
    fill = list_fill[r.site];
    if (fill > 0 && $urandom_range(0, 9) < 7)
      r.slot = SLOT_W'($urandom_range(0, (fill > MAX_SLOTS - 1) ? MAX_SLOTS - 1 : fill));
    else
      r.slot = SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
  endtask

  // Result side: check each transaction, stall in bursts, one long hold-off
  initial begin : result_sink
    result_t got;
    int hold_left;
    int stall_left;
    bit hold_done;
    hold_left = 0;
    stall_left = 0;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        got = '{rsp_ch.inserted, rsp_ch.insert_position, rsp_ch.entry_count,
                rsp_ch.haplotype_total, rsp_ch.read_haplotype, rsp_ch.read_length,
                rsp_ch.read_valid};
        if (due_results.size() == 0) begin
          $display("%0t: result with nothing expected, got %p", $time, got);
          errors++;
        end else begin
          check_result(due_results.pop_front(), got);
        end
      end
      if (!hold_done && phase_no == HOLD_PHASE) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // End the run if no transaction moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus: directed rows, then random phases over a range of capacities
  initial begin : stimulus
    request_t r;
    logic [CAP_W-1:0] cap_val;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.kind <= KIND_ADD;
    req_ch.haplotype <= '0;
    req_ch.match_length <= '0;
    req_ch.site <= '0;
    req_ch.slot <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed rows at the reset capacity
    for (int n = 0; n < DIR_ROWS; n++) begin
      send_request(PLAN[n].req, PLAN[n].typed, PLAN[n].res);
      sender_gap();
    end
    drain_phase();

    // Random phases: wide limits first so lists fill, then lowered limits
    for (int p = 0; p < 8; p++) begin
      phase_no = p + 2;
      calm = (p == 7);
      case (p)
        0: cap_val = 7'd127;
        1: cap_val = 7'd64;
        2: cap_val = 7'd2;
        3: cap_val = 7'd1;
        4: cap_val = 7'd0;
        5: cap_val = 7'd16;
        6: cap_val = CAP_W'($urandom_range(1, MAX_SLOTS));
        default: cap_val = CAP_RESET;
      endcase
      set_capacity(cap_val);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_request(r);
        send_request(r, 1'b0, '0);
        sender_gap();
      end
      drain_phase();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d adds (%0d kept, %0d dropped) and %0d reads (%0d on a stored entry)",
             adds_seen, adds_kept, adds_seen - adds_kept, reads_seen, reads_hit);
    $display("Capacity settings: %0d; longest list: %0d entries; total saturation reached: %0d",
             cap_settings, longest_list, saturated);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
